### sv/phgs_pkg.sv
// Shared types, codes and constants of the gain-scheduled heater PID block.
`default_nettype none
package phgs_pkg;

    localparam int SCHEDULE_STEPS_DEF = 26;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_KP_BASE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI_BASE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD_BASE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_SECONDS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOT_THRESH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCHED_START  = 3'd5;

    localparam logic [31:0] KP_BASE_RST      = 32'd16777216;
    localparam logic [31:0] KI_BASE_RST      = 32'd58720;
    localparam logic [31:0] KD_BASE_RST      = 32'd67108864;
    localparam logic [3:0]  TICK_RST         = 4'd2;
    localparam logic [13:0] HOT_THRESH_RST   = 14'd7570;
    localparam logic [11:0] SCHED_START_RST  = 12'd2350;

    localparam logic [31:0] EXP_SEVENTH_Q24      = 32'd19353609;
    localparam logic [31:0] EXP_FIFTEENTH_Q24    = 32'd17933822;
    localparam logic [31:0] EXP_NEG_FIFTEENTH_Q24 = 32'd15695203;
    localparam logic [31:0] KI_FLOOR_NUM         = 32'd805306368;
    localparam logic [63:0] ITERM_LIMIT          = 64'h2000_0000_0000_0000;
    localparam logic [19:0] SP_OFFSET            = 20'd437090;
    localparam logic [63:0] DUTY_FULL_SCALE      = 64'd100 << 29;

    // Reciprocals for the divisions by constants; each is exact over its operand range.
    localparam logic [20:0] RECIP_100    = 21'd1342178;
    localparam int          RECIP_100_SH = 27;
    localparam logic [21:0] RECIP_5      = 22'd3355444;
    localparam int          RECIP_5_SH   = 24;
    localparam logic [11:0] RECIP_10     = 12'd3277;
    localparam int          RECIP_10_SH  = 15;

    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 32;
    localparam int ACC_W     = 40;

    localparam logic [1:0] MODE_STEADY   = 2'd0;
    localparam logic [1:0] MODE_HEATUP   = 2'd1;
    localparam logic [1:0] MODE_COOLDOWN = 2'd2;

    typedef struct packed {
        logic [13:0] measured_temp_k;
        logic [9:0]  command_tenths;
        logic [11:0] target_c_tenths;
    } phgs_in_t;

    typedef struct packed {
        logic [9:0] duty_tenths;
        logic [1:0] mode;
    } phgs_out_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_LATCH, OP_SP_CAP, OP_DIV_FLOOR, OP_FLAGS,
        OP_INTEG, OP_N_CAP, OP_EXP_INIT, OP_EXP_MUL_LO,
        OP_EXP_MUL_HI, OP_EXP_ACC, OP_GAIN_MUL, OP_GAIN_CAP, OP_PT_MUL, OP_PT_CAP,
        OP_IT_MUL, OP_IT_CAP, OP_DT_MUL, OP_DT_DIV, OP_DT_CAP, OP_FINISH
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHECK, ST_SP, ST_FLOOR_DIV, ST_FLOOR_WAIT,
        ST_INTEG, ST_N, ST_EXP_INIT, ST_EXP_LO,
        ST_EXP_HI, ST_EXP_ACC, ST_GAIN_MUL, ST_GAIN_CAP, ST_PT_MUL, ST_PT_CAP,
        ST_IT_MUL, ST_IT_CAP, ST_DT_MUL, ST_DT_DIV, ST_DT_WAIT, ST_DT_CAP, ST_FIN
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic skip;
        logic div_done;
        logic exp_done;
        logic gain_last;
    } dp_status_t;

endpackage
`default_nettype wire

### sv/pid_heater_gain_scheduled_unit.sv
// Top level of the gain-scheduled PID heater controller.
// A tick runs from input transfer to result; its length grows with the schedule step n
//   (0 to SCHEDULE_STEPS-1) and includes two passes of the shared divider.
// One tick at a time: the next input transfer is taken only once the tick is done,
//   even while the previous result still waits in the output register.
// Reset: synchronous and active low; it restores register defaults and controller state.
`default_nettype none
module pid_heater_gain_scheduled_unit
    import phgs_pkg::*;
#(
    parameter int SCHEDULE_STEPS = SCHEDULE_STEPS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire phgs_in_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output phgs_out_t                  m_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);
    // The controller walks each tick through setpoint, mode flags, integral update,
    // gain scheduling and the three PID terms. The datapath holds the loop
    // state and owns the shared multiplier and the iterative divider. Divisions by
    // constants use reciprocal multiplies; the divider serves only the integral floor
    // and the derivative term, whose divisors are registers.
    ctrl_cmd_t  cmd;
    dp_status_t status;

    phgs_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .status (status),
        .cmd    (cmd)
    );

    // The result register sits in the datapath and is written only when the output
    // slot is free, so a finished result is never overwritten before its transfer.
    phgs_datapath #(
        .SCHEDULE_STEPS(SCHEDULE_STEPS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_data   (s_data),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // A tick must finish before the next input is taken, so an input transfer is never followed at once by another.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on two consecutive cycles");

    // The duty cycle is clamped to full scale.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.duty_tenths <= 10'd1000)
        else $error("duty above full scale");

    // A result is only written while the output slot is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_FINISH |-> !m_valid || m_ready)
        else $error("result written over a pending transfer");
endmodule
`default_nettype wire

### sv/phgs_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module phgs_div
    import phgs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [DIV_NUM_W-1:0] numer,
    input  wire logic [DIV_DEN_W-1:0] denom,
    output logic                      done,
    output logic [DIV_NUM_W-1:0]      quot
);
    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                 busy_reg, done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_DEN_W-1:0] rem_reg, den_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;
    logic [DIV_DEN_W-1:0] rem_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[DIV_NUM_W-1]};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= numer;
                den_reg  <= denom;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
endmodule
`default_nettype wire

### sv/phgs_datapath.sv
// Datapath: state, configuration, shared multiplier and divider, result register.
`default_nettype none
module phgs_datapath
    import phgs_pkg::*;
#(
    parameter int SCHEDULE_STEPS = SCHEDULE_STEPS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ctrl_cmd_t             cmd,
    output dp_status_t                 status,
    input  wire phgs_in_t              s_data,
    output phgs_out_t                  m_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);
    localparam int N_W = $clog2(SCHEDULE_STEPS);
    localparam logic [1:0] GAIN_P = 2'd0;
    localparam logic [1:0] GAIN_I = 2'd1;
    localparam logic [1:0] GAIN_D = 2'd2;

    logic [31:0] kp_base_reg, ki_base_reg, kd_base_reg;
    logic [3:0]  tick_reg;
    logic [13:0] hot_reg;
    logic [11:0] start_c_reg;

    logic [13:0] meas_reg;
    logic [9:0]  cmd_reg;
    logic [11:0] tgt_reg;
    logic        started_reg, seeded_reg, heat_reg, cool_reg, dz_reg;
    logic signed [15:0] prev_err_reg, err_reg;
    logic [13:0] prev_sp_reg, sp_reg;
    logic signed [31:0] integ_reg;
    logic [31:0] cur_ki_reg, kp_reg, kd_reg;
    logic [N_W-1:0] n_reg, cnt_reg;
    logic [1:0]  gsel_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [63:0] prod_reg, pp_reg;
    logic signed [63:0] sum_reg;
    logic [21:0] q5_reg;
    phgs_out_t   m_data_reg;

    logic                 div_start, div_done;
    logic [DIV_NUM_W-1:0] div_num, div_q;
    logic [DIV_DEN_W-1:0] div_den;

    phgs_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .numer  (div_num),
        .denom  (div_den),
        .done   (div_done),
        .quot   (div_q)
    );

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647)       sat32 = 32'sh7FFF_FFFF;
        else if (v < -34'sd2147483648) sat32 = 32'sh8000_0000;
        else                           sat32 = v[31:0];
    endfunction

    logic [3:0]  tick_eff;
    logic [31:0] kdiv;
    logic [19:0] sp_num;
    logic [40:0] sp_prod;
    logic [13:0] sp_calc;
    logic [20:0] sp50, sp49, sp51, sp101, sp99, psp49, psp51, m50, m100;
    logic        cool_cond, heat_cond;
    logic signed [31:0] floor_val, integ_fl;
    logic        c_next, h_next;
    logic signed [16:0] err_wide, sum_pe, delta, delta_eff;
    logic signed [21:0] prod_it;
    logic [21:0] abs_it;
    logic [43:0] q5_prod;
    logic [21:0] q5_val;
    logic signed [33:0] integ_sum, heat_add;
    logic signed [31:0] integ_next;
    logic [15:0] abs_err;
    logic [16:0] abs_delta;
    logic [31:0] abs_integ;
    logic [31:0] mul_a, mul_b, step_sel, base_sel, f16;
    logic [63:0] mul_p, pt2, it_mag, gain_rnd;
    logic [31:0] gain_sat;
    logic        applic;
    logic [11:0] n_num, n_quo;
    logic [23:0] n_prod;
    logic [N_W-1:0] n_next;
    logic [39:0] s10, duty_rnd;
    logic [9:0]  duty_next;
    logic [1:0]  mode_next;

    always_comb begin
        tick_eff = (tick_reg == 4'd0) ? 4'd1 : tick_reg;
        kdiv     = (cur_ki_reg == 32'd0) ? 32'd1 : cur_ki_reg;

        // Setpoint: the rounded kelvin value divided by 100 through a reciprocal.
        sp_num  = SP_OFFSET + 20'(cmd_reg) * 20'd416;
        sp_prod = 41'(sp_num) * 41'(RECIP_100);
        sp_calc = 14'(sp_prod >> RECIP_100_SH);

        sp50  = 21'(sp_reg) * 21'd50;
        sp49  = 21'(sp_reg) * 21'd49;
        sp51  = 21'(sp_reg) * 21'd51;
        sp101 = 21'(sp_reg) * 21'd101;
        sp99  = 21'(sp_reg) * 21'd99;
        psp49 = 21'(prev_sp_reg) * 21'd49;
        psp51 = 21'(prev_sp_reg) * 21'd51;
        m50   = 21'(meas_reg) * 21'd50;
        m100  = 21'(meas_reg) * 21'd100;
        cool_cond = (sp50 < psp49) && (m50 > sp51);
        heat_cond = (sp50 > psp51) && (m50 < sp49);
        floor_val = $signed(div_q[31:0]);

        c_next   = cool_reg;
        h_next   = heat_reg;
        integ_fl = integ_reg;
        if (cool_cond) begin
            c_next   = 1'b1;
            h_next   = 1'b0;
            integ_fl = floor_val;
        end else if (heat_cond) begin
            c_next = 1'b0;
            h_next = 1'b1;
            if (integ_reg < floor_val) integ_fl = floor_val;
        end
        if (c_next && (m100 <= sp101)) c_next = 1'b0;
        if (h_next && (m100 >= sp99))  h_next = 1'b0;

        err_wide = $signed({3'b000, sp_calc}) - $signed({3'b000, meas_reg});
        sum_pe   = $signed({prev_err_reg[15], prev_err_reg}) + $signed({err_reg[15], err_reg});
        prod_it  = sum_pe * $signed({1'b0, tick_eff});
        abs_it   = prod_it[21] ? 22'(-prod_it) : 22'(prod_it);
        // Heat-up step magnitude divided by five through a reciprocal.
        q5_prod  = 44'(abs_it) * 44'(RECIP_5);
        q5_val   = 22'(q5_prod >> RECIP_5_SH);

        integ_sum = $signed({{2{integ_reg[31]}}, integ_reg})
                  + $signed({{12{prod_it[21]}}, prod_it});
        heat_add  = prod_it[21] ? -$signed({12'd0, q5_reg})
                                : $signed({12'd0, q5_reg});
        integ_next = integ_reg;
        if (!cool_reg && !heat_reg) begin
            integ_next = sat32(integ_sum);
            if (integ_next < 0) integ_next = '0;
        end else if (heat_reg) begin
            integ_next = sat32($signed({{2{integ_reg[31]}}, integ_reg}) + heat_add);
        end

        delta     = $signed({err_reg[15], err_reg}) - $signed({prev_err_reg[15], prev_err_reg});
        delta_eff = dz_reg ? 17'sd0 : delta;
        abs_delta = delta_eff[16] ? 17'(-delta_eff) : 17'(delta_eff);
        abs_err   = err_reg[15] ? 16'(-err_reg) : 16'(err_reg);
        abs_integ = integ_reg[31] ? 32'(-integ_reg) : 32'(integ_reg);

        case (gsel_reg)
            GAIN_P:  begin step_sel = EXP_FIFTEENTH_Q24;     base_sel = kp_base_reg; end
            GAIN_I:  begin step_sel = EXP_SEVENTH_Q24;       base_sel = ki_base_reg; end
            default: begin step_sel = EXP_NEG_FIFTEENTH_Q24; base_sel = kd_base_reg; end
        endcase
        f16 = 32'((41'(acc_reg) + 41'd128) >> 8);

        case (cmd.op)
            OP_EXP_MUL_LO: begin mul_a = 32'(acc_reg[19:0]);       mul_b = step_sel;  end
            OP_EXP_MUL_HI: begin mul_a = 32'(acc_reg[ACC_W-1:20]); mul_b = step_sel;  end
            OP_GAIN_MUL:   begin mul_a = base_sel;                 mul_b = f16;       end
            OP_PT_MUL:     begin mul_a = kp_reg;                   mul_b = 32'(abs_err); end
            OP_IT_MUL:     begin mul_a = cur_ki_reg;               mul_b = abs_integ; end
            OP_DT_MUL:     begin mul_a = kd_reg;                   mul_b = 32'(abs_delta); end
            default:       begin mul_a = '0;                       mul_b = '0;        end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);

        pt2      = {prod_reg[62:0], 1'b0};
        it_mag   = (prod_reg > ITERM_LIMIT) ? ITERM_LIMIT : prod_reg;
        gain_rnd = (prod_reg + 64'd32768) >> 16;
        gain_sat = (|gain_rnd[63:32]) ? 32'hFFFF_FFFF : gain_rnd[31:0];

        // Schedule step: whole degrees above the start, divided by ten through a reciprocal.
        applic = (meas_reg > hot_reg) && (tgt_reg >= start_c_reg);
        n_num  = applic ? (tgt_reg - start_c_reg) : 12'd0;
        n_prod = 24'(n_num) * 24'(RECIP_10);
        n_quo  = 12'(n_prod >> RECIP_10_SH);
        n_next = (n_quo > 12'(SCHEDULE_STEPS - 1)) ? N_W'(SCHEDULE_STEPS - 1)
                                                   : n_quo[N_W-1:0];

        div_start = 1'b1;
        div_num   = '0;
        div_den   = 32'd1;
        case (cmd.op)
            OP_DIV_FLOOR: begin
                div_num = 64'(KI_FLOOR_NUM);
                div_den = kdiv;
            end
            OP_DT_DIV: begin
                div_num = pt2;
                div_den = 32'(tick_eff);
            end
            default: div_start = 1'b0;
        endcase

        s10      = 40'(sum_reg[35:0]) * 40'd10;
        duty_rnd = (s10 + 40'h10000000) >> 29;
        if (sum_reg <= 0)                           duty_next = 10'd0;
        else if (sum_reg >= $signed(DUTY_FULL_SCALE)) duty_next = 10'd1000;
        else                                        duty_next = duty_rnd[9:0];
        mode_next = cool_reg ? MODE_COOLDOWN : (heat_reg ? MODE_HEATUP : MODE_STEADY);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_base_reg  <= KP_BASE_RST;
            ki_base_reg  <= KI_BASE_RST;
            kd_base_reg  <= KD_BASE_RST;
            tick_reg     <= TICK_RST;
            hot_reg      <= HOT_THRESH_RST;
            start_c_reg  <= SCHED_START_RST;
            started_reg  <= 1'b0;
            seeded_reg   <= 1'b0;
            heat_reg     <= 1'b1;
            cool_reg     <= 1'b0;
            prev_err_reg <= '0;
            prev_sp_reg  <= '0;
            integ_reg    <= '0;
            cur_ki_reg   <= KI_BASE_RST;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_KP_BASE:      kp_base_reg <= cfg_wdata;
                    REG_KI_BASE: begin
                        ki_base_reg <= cfg_wdata;
                        cur_ki_reg  <= cfg_wdata;
                    end
                    REG_KD_BASE:      kd_base_reg <= cfg_wdata;
                    REG_TICK_SECONDS: tick_reg    <= cfg_wdata[3:0];
                    REG_HOT_THRESH:   hot_reg     <= cfg_wdata[13:0];
                    REG_SCHED_START:  start_c_reg <= cfg_wdata[11:0];
                    default: ;
                endcase
            end
            case (cmd.op)
                OP_LATCH: begin
                    meas_reg <= s_data.measured_temp_k;
                    cmd_reg  <= s_data.command_tenths;
                    tgt_reg  <= s_data.target_c_tenths;
                    if (!seeded_reg) begin
                        prev_sp_reg <= s_data.measured_temp_k;
                        seeded_reg  <= 1'b1;
                    end
                end
                OP_SP_CAP: begin
                    sp_reg  <= sp_calc;
                    err_reg <= err_wide[15:0];
                    if (!started_reg) begin
                        started_reg  <= 1'b1;
                        prev_err_reg <= err_wide[15:0];
                    end
                end
                OP_FLAGS: begin
                    cool_reg  <= c_next;
                    heat_reg  <= h_next;
                    integ_reg <= integ_fl;
                    dz_reg    <= cool_cond || heat_cond;
                    q5_reg    <= q5_val;
                end
                OP_INTEG:  integ_reg <= integ_next;
                OP_N_CAP: begin
                    n_reg    <= n_next;
                    gsel_reg <= GAIN_P;
                end
                OP_EXP_INIT: begin
                    acc_reg <= ACC_W'(1) << 24;
                    cnt_reg <= '0;
                end
                OP_EXP_MUL_LO: prod_reg <= mul_p;
                OP_EXP_MUL_HI: pp_reg   <= mul_p;
                OP_EXP_ACC: begin
                    acc_reg <= ACC_W'((prod_reg + (pp_reg << 20) + 64'h800000) >> 24);
                    cnt_reg <= cnt_reg + 1'b1;
                end
                OP_GAIN_MUL, OP_PT_MUL, OP_IT_MUL, OP_DT_MUL: prod_reg <= mul_p;
                OP_GAIN_CAP: begin
                    case (gsel_reg)
                        GAIN_P:  kp_reg     <= gain_sat;
                        GAIN_I:  cur_ki_reg <= gain_sat;
                        default: kd_reg     <= gain_sat;
                    endcase
                    gsel_reg <= gsel_reg + 2'd1;
                end
                OP_PT_CAP: sum_reg <= err_reg[15] ? -$signed(pt2) : $signed(pt2);
                OP_IT_CAP: sum_reg <= integ_reg[31] ? sum_reg - $signed(it_mag)
                                                    : sum_reg + $signed(it_mag);
                OP_DT_CAP: sum_reg <= delta_eff[16] ? sum_reg - $signed(div_q)
                                                    : sum_reg + $signed(div_q);
                OP_FINISH: begin
                    m_data_reg.duty_tenths <= duty_next;
                    m_data_reg.mode        <= mode_next;
                    prev_err_reg           <= err_reg;
                    prev_sp_reg            <= sp_reg;
                end
                default: ;
            endcase
        end
    end

    assign m_data           = m_data_reg;
    assign status.skip      = !started_reg && (cmd_reg == 10'd0);
    assign status.div_done  = div_done;
    assign status.exp_done  = (cnt_reg == n_reg);
    assign status.gain_last = (gsel_reg == GAIN_D);
endmodule
`default_nettype wire

### sv/phgs_ctrl.sv
// Controller state machine that sequences one control tick through the datapath.
`default_nettype none
module phgs_ctrl
    import phgs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);
    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;
        case (state_reg)
            ST_IDLE:       if (s_valid) state_next = ST_CHECK;
            ST_CHECK:      state_next = status.skip ? ST_IDLE : ST_SP;
            ST_SP:         state_next = ST_FLOOR_DIV;
            ST_FLOOR_DIV:  state_next = ST_FLOOR_WAIT;
            ST_FLOOR_WAIT: if (status.div_done) state_next = ST_INTEG;
            ST_INTEG:      state_next = ST_N;
            ST_N:          state_next = ST_EXP_INIT;
            ST_EXP_INIT:   state_next = ST_EXP_LO;
            ST_EXP_LO:     state_next = status.exp_done ? ST_GAIN_MUL : ST_EXP_HI;
            ST_EXP_HI:     state_next = ST_EXP_ACC;
            ST_EXP_ACC:    state_next = ST_EXP_LO;
            ST_GAIN_MUL:   state_next = ST_GAIN_CAP;
            ST_GAIN_CAP:   state_next = status.gain_last ? ST_PT_MUL : ST_EXP_INIT;
            ST_PT_MUL:     state_next = ST_PT_CAP;
            ST_PT_CAP:     state_next = ST_IT_MUL;
            ST_IT_MUL:     state_next = ST_IT_CAP;
            ST_IT_CAP:     state_next = ST_DT_MUL;
            ST_DT_MUL:     state_next = ST_DT_DIV;
            ST_DT_DIV:     state_next = ST_DT_WAIT;
            ST_DT_WAIT:    if (status.div_done) state_next = ST_DT_CAP;
            ST_DT_CAP:     state_next = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.op  = OP_NOP;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) cmd.op = OP_LATCH;
            end
            ST_SP:         cmd.op = OP_SP_CAP;
            ST_FLOOR_DIV:  cmd.op = OP_DIV_FLOOR;
            ST_FLOOR_WAIT: if (status.div_done) cmd.op = OP_FLAGS;
            ST_INTEG:      cmd.op = OP_INTEG;
            ST_N:          cmd.op = OP_N_CAP;
            ST_EXP_INIT:   cmd.op = OP_EXP_INIT;
            ST_EXP_LO:     if (!status.exp_done) cmd.op = OP_EXP_MUL_LO;
            ST_EXP_HI:     cmd.op = OP_EXP_MUL_HI;
            ST_EXP_ACC:    cmd.op = OP_EXP_ACC;
            ST_GAIN_MUL:   cmd.op = OP_GAIN_MUL;
            ST_GAIN_CAP:   cmd.op = OP_GAIN_CAP;
            ST_PT_MUL:     cmd.op = OP_PT_MUL;
            ST_PT_CAP:     cmd.op = OP_PT_CAP;
            ST_IT_MUL:     cmd.op = OP_IT_MUL;
            ST_IT_CAP:     cmd.op = OP_IT_CAP;
            ST_DT_MUL:     cmd.op = OP_DT_MUL;
            ST_DT_DIV:     cmd.op = OP_DT_DIV;
            ST_DT_WAIT:    if (status.div_done) cmd.op = OP_DT_CAP;
            ST_FIN:        if (out_free) cmd.op = OP_FINISH;
            default:       cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
endmodule
`default_nettype wire

### sim/pid_heater_gain_scheduled_unit_tb.sv
// Self-checking testbench for the gain-scheduled PID heater controller.
`timescale 1ns / 100ps
module pid_heater_gain_scheduled_unit_tb;
    import phgs_pkg::*;

    // The settle time covers the worst-case tick with margin.
    localparam int SETTLE_CYCLES = 800;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 106;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    phgs_in_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    phgs_out_t             m_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    pid_heater_gain_scheduled_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 0;
    end

    // Shadow copy of the controller: register file and loop state.
    logic [31:0] kp_reg, ki_reg, kd_reg;
    logic [3:0]  tick_reg;
    logic [13:0] hot_reg;
    logic [11:0] start_reg;
    bit          loop_started, sp_seeded, heating, cooling;
    longint      last_error, last_setpoint, integ;
    logic [31:0] ki_now;

    phgs_out_t duty_queue[$];
    int        error_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Gain factor exp(n*x) in Q.16, built by n rounded Q.24 multiplies.
    function automatic longint unsigned gain_factor(input longint unsigned step, input int n);
        longint unsigned acc;
        acc = 64'd1 << 24;
        for (int i = 0; i < n; i++)
            acc = (acc * step + (64'd1 << 23)) >> 24;
        return (acc + 128) >> 8;
    endfunction

    function automatic logic [31:0] scaled_gain(input logic [31:0] base,
                                                input longint unsigned f16);
        longint unsigned p;
        p = (longint'(base) * f16 + 32768) >> 16;
        return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    endfunction

    function automatic longint unsigned ki_floor();
        longint unsigned kdiv;
        kdiv = (ki_now == 0) ? 64'd1 : longint'(ki_now);
        return longint'(KI_FLOOR_NUM) / kdiv;
    endfunction

    // One control tick of the controller; returns whether a duty result comes out.
    function automatic bit control_tick(input phgs_in_t item, output phgs_out_t res);
        longint sp, m, psp, err, delta, tick, pterm, iterm, dterm, total;
        longint unsigned mag;
        int n;
        logic [31:0] kp, ki, kd;
        res = '0;
        if (!sp_seeded) begin
            last_setpoint = item.measured_temp_k;
            sp_seeded = 1;
        end
        if (!loop_started && item.command_tenths == 0)
            return 0;
        sp = (437040 + 416 * longint'(item.command_tenths) + 50) / 100;
        m = item.measured_temp_k;
        psp = last_setpoint;
        err = sp - m;
        if (!loop_started) begin
            loop_started = 1;
            last_error = err;
        end
        tick = (tick_reg == 0) ? 1 : tick_reg;
        delta = err - last_error;
        if (50 * sp < 49 * psp && 50 * m > 51 * sp) begin
            cooling = 1;
            heating = 0;
            delta = 0;
            integ = longint'(ki_floor());
        end else if (50 * sp > 51 * psp && 50 * m < 49 * sp) begin
            heating = 1;
            cooling = 0;
            delta = 0;
            if (integ < longint'(ki_floor()))
                integ = longint'(ki_floor());
        end
        if (cooling && 100 * m <= 101 * sp)
            cooling = 0;
        if (heating && 100 * m >= 99 * sp)
            heating = 0;
        if (!cooling && !heating) begin
            integ = clamp32(integ + (last_error + err) * tick);
            if (integ < 0)
                integ = 0;
        end else if (heating) begin
            integ = clamp32(integ + ((last_error + err) * tick) / 5);
        end
        // Scheduling applies only when hot and the target reaches the schedule start.
        n = 0;
        if (item.measured_temp_k > hot_reg && item.target_c_tenths >= start_reg) begin
            n = (item.target_c_tenths - start_reg) / 10;
            if (n > SCHEDULE_STEPS_DEF - 1)
                n = SCHEDULE_STEPS_DEF - 1;
        end
        kp = scaled_gain(kp_reg, gain_factor(EXP_FIFTEENTH_Q24, n));
        ki = scaled_gain(ki_reg, gain_factor(EXP_SEVENTH_Q24, n));
        kd = scaled_gain(kd_reg, gain_factor(EXP_NEG_FIFTEENTH_Q24, n));
        ki_now = ki;
        pterm = 2 * longint'(kp) * err;
        mag = (integ < 0) ? longint'(-integ) : longint'(integ);
        mag = longint'(ki) * mag;
        if (mag > ITERM_LIMIT)
            mag = ITERM_LIMIT;
        iterm = (integ < 0) ? -longint'(mag) : longint'(mag);
        dterm = (2 * longint'(kd) * delta) / tick;
        total = pterm + iterm + dterm;
        if (total <= 0)
            res.duty_tenths = 0;
        else if (total >= (64'sd100 <<< 29))
            res.duty_tenths = 10'd1000;
        else
            res.duty_tenths = 10'((total * 10 + (64'sd1 <<< 28)) >>> 29);
        res.mode = cooling ? MODE_COOLDOWN : (heating ? MODE_HEATUP : MODE_STEADY);
        last_error = err;
        last_setpoint = sp & 14'h3FFF;
        return 1;
    endfunction

    // Register writes are issued back to back; the caller lowers the write enable.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_KP_BASE:      kp_reg = val;
            REG_KI_BASE: begin
                ki_reg = val;
                ki_now = val;
            end
            REG_KD_BASE:      kd_reg = val;
            REG_TICK_SECONDS: tick_reg = val[3:0];
            REG_HOT_THRESH:   hot_reg = val[13:0];
            REG_SCHED_START:  start_reg = val[11:0];
            default: ;
        endcase
    endtask

    task automatic load_gains(input logic [31:0] kp, input logic [31:0] ki,
                              input logic [31:0] kd, input logic [3:0] tick,
                              input logic [13:0] hot, input logic [11:0] start);
        write_reg(REG_KP_BASE, kp);
        write_reg(REG_KI_BASE, ki);
        write_reg(REG_KD_BASE, kd);
        write_reg(REG_TICK_SECONDS, {28'd0, tick});
        write_reg(REG_HOT_THRESH, {18'd0, hot});
        write_reg(REG_SCHED_START, {20'd0, start});
        cfg_we <= 1'b0;
    endtask

    // Offers one tick to the block and books the expected duty once it is taken.
    task automatic offer_tick(input phgs_in_t item, input bit typed, input bit typed_any,
                              input phgs_out_t typed_res);
        phgs_out_t res;
        bit produced;
        s_data <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        produced = control_tick(item, res);
        if (typed) begin
            produced = typed_any;
            res = typed_res;
        end
        if (produced)
            duty_queue.push_back(res);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Sender holds off until every booked duty has come back, then lets the block settle.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (duty_queue.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Receiver side: random back-pressure at the configured rate.
    always @(posedge aclk) begin
        if (recv_stall_pct == 0)
            m_ready <= 1'b1;
        else
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every result transfer is compared with the oldest booked duty.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (duty_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected result duty=%0d mode=%0d",
                                          m_data.duty_tenths, m_data.mode));
            end else begin
                if (m_data.duty_tenths !== duty_queue[0].duty_tenths)
                    report_mismatch($sformatf("duty got %0d want %0d",
                                              m_data.duty_tenths, duty_queue[0].duty_tenths));
                if (m_data.mode !== duty_queue[0].mode)
                    report_mismatch($sformatf("mode got %0d want %0d",
                                              m_data.mode, duty_queue[0].mode));
                void'(duty_queue.pop_front());
            end
        end
    end

    typedef struct {
        logic [13:0] meas;
        logic [9:0]  cmd;
        logic [11:0] tgt;
        bit          typed;
        bit          any;
        logic [9:0]  duty;
        logic [1:0]  mode;
    } tick_row_t;

    // Directed ticks under the reset settings. Typed rows: idle commands before the loop
    // starts, full heat from cold, and a hot plate forced into cooldown.
    tick_row_t directed_rows[] = '{
        '{14'd4800,  10'd0,    12'd0,    1, 0, 10'd0,    MODE_STEADY},
        '{14'd16383, 10'd0,    12'd2600, 1, 0, 10'd0,    MODE_STEADY},
        '{14'd0,     10'd1000, 12'd0,    1, 1, 10'd1000, MODE_HEATUP},
        '{14'd16383, 10'd0,    12'd2600, 1, 1, 10'd0,    MODE_COOLDOWN},
        '{14'd4400,  10'd0,    12'd0,    0, 0, 10'd0,    MODE_STEADY},
        '{14'd4370,  10'd0,    12'd0,    0, 0, 10'd0,    MODE_STEADY},
        '{14'd4360,  10'd0,    12'd0,    0, 0, 10'd0,    MODE_STEADY},
        '{14'd5000,  10'd500,  12'd1300, 0, 0, 10'd0,    MODE_STEADY},
        '{14'd6000,  10'd500,  12'd1300, 0, 0, 10'd0,    MODE_STEADY},
        '{14'd6450,  10'd500,  12'd1300, 0, 0, 10'd0,    MODE_STEADY},
        '{14'd6460,  10'd500,  12'd1300, 0, 0, 10'd0,    MODE_STEADY},
        '{14'd8000,  10'd1000, 12'd2600, 0, 0, 10'd0,    MODE_STEADY},
        '{14'd8400,  10'd1000, 12'd2350, 0, 0, 10'd0,    MODE_STEADY},
        '{14'd8500,  10'd1000, 12'd2450, 0, 0, 10'd0,    MODE_STEADY},
        '{14'd8530,  10'd1000, 12'd2600, 0, 0, 10'd0,    MODE_STEADY},
        '{14'd8600,  10'd1000, 12'd2349, 0, 0, 10'd0,    MODE_STEADY},
        '{14'd7570,  10'd1000, 12'd2600, 0, 0, 10'd0,    MODE_STEADY},
        '{14'd7571,  10'd1000, 12'd2600, 0, 0, 10'd0,    MODE_STEADY},
        '{14'd4375,  10'd1,    12'd4095, 0, 0, 10'd0,    MODE_STEADY},
        '{14'd0,     10'd1,    12'd0,    0, 0, 10'd0,    MODE_STEADY}
    };

    initial begin
        phgs_in_t  item;
        phgs_out_t typed_res;
        int        sp_now;
        int        cmd_now;
        kp_reg = KP_BASE_RST;
        ki_reg = KI_BASE_RST;
        kd_reg = KD_BASE_RST;
        tick_reg = TICK_RST;
        hot_reg = HOT_THRESH_RST;
        start_reg = SCHED_START_RST;
        ki_now = KI_BASE_RST;
        loop_started = 0;
        sp_seeded = 0;
        heating = 1;
        cooling = 0;
        last_error = 0;
        last_setpoint = 0;
        integ = 0;
        cmd_now = 500;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            item.measured_temp_k = directed_rows[i].meas;
            item.command_tenths = directed_rows[i].cmd;
            item.target_c_tenths = directed_rows[i].tgt;
            typed_res.duty_tenths = directed_rows[i].duty;
            typed_res.mode = directed_rows[i].mode;
            offer_tick(item, directed_rows[i].typed, directed_rows[i].any, typed_res);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            // The block must be idle before any register changes.
            drain_results();
            case (phase)
                0: load_gains(32'd0, 32'd1, 32'd0, 4'd1, 14'd0, 12'd0);
                1: load_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15,
                              14'd16383, 12'd2600);
                2: begin
                    // Zero tick length falls back to one, and so does a zero integral gain as the floor divisor.
                    load_gains(KP_BASE_RST, 32'd0, KD_BASE_RST, 4'd0,
                               HOT_THRESH_RST, SCHED_START_RST);
                end
                3: begin
                    // Writes to indexes past the last register must be ignored.
                    write_reg(3'd6, $urandom);
                    write_reg(3'd7, $urandom);
                    load_gains(KP_BASE_RST, KI_BASE_RST, KD_BASE_RST, TICK_RST,
                               HOT_THRESH_RST, SCHED_START_RST);
                end
                default: load_gains($urandom_range(32'h0800_0000), $urandom_range(1, 32'h0010_0000),
                                    $urandom, 4'($urandom_range(1, 15)),
                                    14'($urandom_range(16383)), 12'($urandom_range(2600)));
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // Mostly hold the command so the loop settles; sometimes step it hard.
                if ($urandom_range(99) < 25) begin
                    case ($urandom_range(9))
                        0: cmd_now = 0;
                        1: cmd_now = 1000;
                        default: cmd_now = $urandom_range(1000);
                    endcase
                end
                sp_now = (437040 + 416 * cmd_now + 50) / 100;
                case ($urandom_range(9))
                    0, 1: item.measured_temp_k = 14'($urandom_range(16383));
                    2: item.measured_temp_k = 14'($urandom_range(sp_now));
                    default: begin
                        sp_now = sp_now + $urandom_range(600) - 300;
                        item.measured_temp_k = 14'((sp_now < 0) ? 0 : sp_now);
                    end
                endcase
                item.command_tenths = 10'(cmd_now);
                if ($urandom_range(1) == 0)
                    item.target_c_tenths = 12'($urandom_range(2600, start_reg));
                else
                    item.target_c_tenths = 12'($urandom_range(2600));
                offer_tick(item, 0, 0, typed_res);
            end
        end

        drain_results();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
